/* rtl/tesr_pkg.sv */
`default_nettype none

package tesr_pkg;

    // event types
    localparam logic [15:0] MODE_SYNC = 16'd0;
    localparam logic [15:0] MODE_KEY  = 16'd1;
    localparam logic [15:0] MODE_REL  = 16'd2;
    localparam logic [15:0] MODE_ABS  = 16'd3;

    // event codes
    localparam logic [15:0] ABS_X      = 16'd0;
    localparam logic [15:0] ABS_Y      = 16'd1;
    localparam logic [15:0] REL_WHEEL  = 16'd8;
    localparam logic [15:0] KEY_LEFT   = 16'h0110;
    localparam logic [15:0] KEY_MIDDLE = 16'h0112;

    // reset values and limits
    localparam logic [14:0] POS_RESET          = 15'd16384;
    localparam logic [14:0] POS_MAX            = 15'd32767;
    localparam logic [23:0] CLICK_WINDOW_RESET = 24'd500000;
    localparam logic [7:0]  COUNT_MAX          = 8'd255;
    localparam logic [15:0] WHEEL_MAX          = 16'h7fff;
    localparam logic [15:0] WHEEL_MIN          = 16'h8000;

    typedef enum logic [1:0] {
        KIND_MOVE  = 2'd0,
        KIND_DOWN  = 2'd1,
        KIND_UP    = 2'd2,
        KIND_WHEEL = 2'd3
    } t_kind;

    typedef struct packed {
        logic [15:0] mode;
        logic [15:0] event_code;
        logic [31:0] event_value;
        logic [47:0] timestamp;
    } t_event;

    typedef struct packed {
        t_kind       report_kind;
        logic [2:0]  buttons;
        logic [14:0] pos_x;
        logic [14:0] pos_y;
        logic [7:0]  click_count;
        logic [15:0] wheel_delta;
        logic [47:0] report_time;
        logic        last;
    } t_report;

endpackage

`default_nettype wire

/* rtl/tesr_in_reg.sv */
`default_nettype none

module tesr_in_reg
    import tesr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_event i_item,
    input  wire logic   i_consume,
    output logic        o_valid,
    output t_event      o_item
);

    logic   r_valid;
    t_event r_item;

    // free, or the held item leaves this cycle
    assign o_ready = !r_valid || i_consume;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/tesr_core.sv */
`default_nettype none

module tesr_core
    import tesr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [23:0] i_cfg_click_window,
    input  wire logic        i_item_valid,
    input  wire t_event      i_item,
    input  wire logic        i_out_free,
    output logic             o_consume,
    output logic             o_emit,
    output t_report          o_report
);

    logic [23:0] r_window;
    logic [14:0] r_pend_x, r_pend_y, r_shown_x, r_shown_y;
    logic [2:0]  r_pend_btn, r_shown_btn;
    logic [15:0] r_wheel_acc;
    logic [47:0] r_last_time;
    logic [1:0]  r_last_btn;
    logic        r_last_valid;
    logic [7:0]  r_count;

    logic [14:0] n_pend_x, n_pend_y, n_shown_x, n_shown_y;
    logic [2:0]  n_pend_btn, n_shown_btn;
    logic [15:0] n_wheel_acc;
    logic [47:0] n_last_time;
    logic [1:0]  n_last_btn;
    logic        n_last_valid;
    logic [7:0]  n_count;

    logic [14:0] clamped;
    logic [33:0] wheel_diff;
    logic [15:0] wheel_sat;
    logic        key_hit;
    logic [1:0]  key_idx;
    logic        move_pend;
    logic [2:0]  btn_diff;
    logic        wheel_pend;
    logic [1:0]  btn_idx;
    logic [2:0]  btn_bit;
    logic [47:0] gap;
    logic        multi;
    logic [7:0]  down_count;

    // position clamp to 0..32767
    always_comb begin
        if (i_item.event_value[31]) begin
            clamped = '0;
        end else if (|i_item.event_value[30:15]) begin
            clamped = POS_MAX;
        end else begin
            clamped = i_item.event_value[14:0];
        end
    end

    // saturating wheel accumulate, steps subtract
    always_comb begin
        wheel_diff = {{18{r_wheel_acc[15]}}, r_wheel_acc}
                   - {{2{i_item.event_value[31]}}, i_item.event_value};
        if (wheel_diff[33] && !(&wheel_diff[32:15])) begin
            wheel_sat = WHEEL_MIN;
        end else if (!wheel_diff[33] && (|wheel_diff[32:15])) begin
            wheel_sat = WHEEL_MAX;
        end else begin
            wheel_sat = wheel_diff[15:0];
        end
    end

    assign key_hit = (i_item.event_code >= KEY_LEFT) && (i_item.event_code <= KEY_MIDDLE);
    assign key_idx = i_item.event_code[1:0];

    assign move_pend  = (r_pend_x != r_shown_x) || (r_pend_y != r_shown_y);
    assign btn_diff   = r_pend_btn ^ r_shown_btn;
    assign wheel_pend = (r_wheel_acc != '0);

    // lowest changed button first
    always_comb begin
        if (btn_diff[0]) begin
            btn_idx = 2'd0;
        end else if (btn_diff[1]) begin
            btn_idx = 2'd1;
        end else begin
            btn_idx = 2'd2;
        end
    end
    assign btn_bit = 3'b001 << btn_idx;

    // multi-click detect, gap taken mod 2^48
    assign gap   = i_item.timestamp - r_last_time;
    assign multi = r_last_valid && (r_last_btn == btn_idx) && (gap <= {24'd0, r_window});
    assign down_count = !multi ? 8'd1 : (r_count == COUNT_MAX) ? COUNT_MAX : r_count + 8'd1;

    always_comb begin
        n_pend_x     = r_pend_x;
        n_pend_y     = r_pend_y;
        n_shown_x    = r_shown_x;
        n_shown_y    = r_shown_y;
        n_pend_btn   = r_pend_btn;
        n_shown_btn  = r_shown_btn;
        n_wheel_acc  = r_wheel_acc;
        n_last_time  = r_last_time;
        n_last_btn   = r_last_btn;
        n_last_valid = r_last_valid;
        n_count      = r_count;
        o_consume    = 1'b0;
        o_emit       = 1'b0;

        o_report.report_kind = KIND_MOVE;
        o_report.buttons     = r_shown_btn;
        o_report.pos_x       = r_shown_x;
        o_report.pos_y       = r_shown_y;
        o_report.click_count = '0;
        o_report.wheel_delta = '0;
        o_report.report_time = i_item.timestamp;
        o_report.last        = 1'b0;

        if (i_item_valid) begin
            unique case (i_item.mode)
                MODE_ABS: begin
                    o_consume = 1'b1;
                    if (i_item.event_code == ABS_X) begin
                        n_pend_x = clamped;
                    end else if (i_item.event_code == ABS_Y) begin
                        n_pend_y = clamped;
                    end
                end
                MODE_REL: begin
                    o_consume = 1'b1;
                    if (i_item.event_code == REL_WHEEL) begin
                        n_wheel_acc = wheel_sat;
                    end
                end
                MODE_KEY: begin
                    o_consume = 1'b1;
                    if (key_hit) begin
                        n_pend_btn[key_idx] = (i_item.event_value != '0);
                    end
                end
                MODE_SYNC: begin
                    // one report per cycle while the output register is free, item held until the final one
                    if (i_out_free) begin
                        if (move_pend) begin
                            o_emit         = 1'b1;
                            n_shown_x      = r_pend_x;
                            n_shown_y      = r_pend_y;
                            o_report.pos_x = r_pend_x;
                            o_report.pos_y = r_pend_y;
                            o_report.last  = !(|btn_diff) && !wheel_pend;
                        end else if (|btn_diff) begin
                            o_emit           = 1'b1;
                            n_shown_btn      = r_shown_btn ^ btn_bit;
                            o_report.buttons = r_shown_btn ^ btn_bit;
                            o_report.last    = !(|(btn_diff & ~btn_bit)) && !wheel_pend;
                            if (|(r_pend_btn & btn_bit)) begin
                                o_report.report_kind = KIND_DOWN;
                                o_report.click_count = down_count;
                                n_count      = down_count;
                                n_last_btn   = btn_idx;
                                n_last_valid = 1'b1;
                                n_last_time  = i_item.timestamp;
                            end else begin
                                o_report.report_kind = KIND_UP;
                            end
                        end else if (wheel_pend) begin
                            o_emit               = 1'b1;
                            o_report.report_kind = KIND_WHEEL;
                            o_report.wheel_delta = r_wheel_acc;
                            o_report.last        = 1'b1;
                            n_wheel_acc          = '0;
                        end
                        o_consume = !o_emit || o_report.last;
                    end
                end
                default: begin
                    o_consume = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= CLICK_WINDOW_RESET;
            r_pend_x     <= POS_RESET;
            r_pend_y     <= POS_RESET;
            r_shown_x    <= POS_RESET;
            r_shown_y    <= POS_RESET;
            r_pend_btn   <= '0;
            r_shown_btn  <= '0;
            r_wheel_acc  <= '0;
            r_last_time  <= '0;
            r_last_btn   <= '0;
            r_last_valid <= 1'b0;
            r_count      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_window <= i_cfg_click_window;
            end
            r_pend_x     <= n_pend_x;
            r_pend_y     <= n_pend_y;
            r_shown_x    <= n_shown_x;
            r_shown_y    <= n_shown_y;
            r_pend_btn   <= n_pend_btn;
            r_shown_btn  <= n_shown_btn;
            r_wheel_acc  <= n_wheel_acc;
            r_last_time  <= n_last_time;
            r_last_btn   <= n_last_btn;
            r_last_valid <= n_last_valid;
            r_count      <= n_count;
        end
    end

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> i_out_free && i_item_valid)
        else $error("report made while output register is busy");

    a_move_catches_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_report.report_kind == KIND_MOVE) |=>
            (r_shown_x == $past(r_pend_x)) && (r_shown_y == $past(r_pend_y)))
        else $error("shown position not updated by move report");

    a_wheel_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_report.report_kind == KIND_WHEEL) |=> (r_wheel_acc == '0))
        else $error("wheel accumulator not cleared after wheel report");

    a_down_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_report.report_kind == KIND_DOWN) |-> (o_report.click_count != '0))
        else $error("button down report with zero click count");

    a_wheel_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_report.report_kind == KIND_WHEEL) |-> o_report.last && o_consume)
        else $error("wheel report not final for its sync item");

endmodule

`default_nettype wire

/* rtl/tesr_out_reg.sv */
`default_nettype none

module tesr_out_reg
    import tesr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_report i_report,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_report      o_report
);

    logic    r_valid;
    t_report r_report;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_report = r_report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_report <= i_report;
        end
    end

endmodule

`default_nettype wire

/* rtl/tablet_event_sync_reporter_top.sv */
// tablet pointer event decoder with sync-driven reports
//
// input channel (i_in_valid / o_in_ready): one evdev-style event per item,
//   type, code, signed value and 48-bit microsecond timestamp
// output channel (o_out_valid / i_out_ready): one report per item; a sync
//   event gives, in order, a move, one report per changed button (lowest
//   first) and a wheel report, with o_last on the final one
// config channel (i_cfg_valid / o_cfg_ready): click window in microseconds,
//   always ready, write only while the block is idle
//
// path: an item is held in the input register; its first report is then
//   loaded into the output register once that register is free
// flow: key, relative, absolute and ignored events pass without waiting,
//   even while a report is stalled at the output; a sync event holds the
//   input register until its final report (one to five) is loaded, or while
//   the output register is busy if it makes none; that register is the limit
// reset: positions go to one half, buttons, wheel and click history clear,
//   click window returns to 500000
// stall: a report waits in the output register with its payload held; a
//   sync item waits behind it, and the input stalls once that item is held
`default_nettype none

module tablet_event_sync_reporter_top
    import tesr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    // config
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic        [23:0] i_click_window,

    // event items
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic        [15:0] i_mode,
    input  wire logic        [15:0] i_event_code,
    input  wire logic signed [31:0] i_event_value,
    input  wire logic        [47:0] i_timestamp,

    // report items
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic             [1:0]  o_report_kind,
    output logic             [2:0]  o_buttons,
    output logic             [14:0] o_pos_x,
    output logic             [14:0] o_pos_y,
    output logic             [7:0]  o_click_count,
    output logic signed      [15:0] o_wheel_delta,
    output logic             [47:0] o_report_time,
    output logic                    o_last
);

    t_event  in_item, held_item;
    logic    held_valid;
    logic    consume;
    logic    out_free;
    logic    emit;
    t_report core_report, out_report;

    // register always writable
    assign o_cfg_ready = 1'b1;

    assign in_item.mode        = i_mode;
    assign in_item.event_code  = i_event_code;
    assign in_item.event_value = i_event_value;
    assign in_item.timestamp   = i_timestamp;

    tesr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .i_consume (consume),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    // pending/shown state and report selection
    tesr_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_click_window (i_click_window),
        .i_item_valid       (held_valid),
        .i_item             (held_item),
        .i_out_free         (out_free),
        .o_consume          (consume),
        .o_emit             (emit),
        .o_report           (core_report)
    );

    tesr_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit),
        .i_report (core_report),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_report (out_report)
    );

    assign o_report_kind = out_report.report_kind;
    assign o_buttons     = out_report.buttons;
    assign o_pos_x       = out_report.pos_x;
    assign o_pos_y       = out_report.pos_y;
    assign o_click_count = out_report.click_count;
    assign o_wheel_delta = out_report.wheel_delta;
    assign o_report_time = out_report.report_time;
    assign o_last        = out_report.last;

endmodule

`default_nettype wire

/* tb/sv/tablet_event_sync_reporter_top_tb.sv */
`default_nettype none

module tablet_event_sync_reporter_top_tb;
    import tesr_pkg::*;

    // codes the package leaves out
    localparam logic [15:0] KEY_RIGHT   = KEY_LEFT + 16'd1;
    localparam logic [15:0] SYN_REPORT  = 16'd0;
    localparam logic [15:0] MODE_UNUSED = 16'hffff;
    localparam logic [15:0] ABS_UNUSED  = 16'd2;
    localparam logic [15:0] KEY_PAST    = KEY_MIDDLE + 16'd1;

    localparam int DRAIN_CYCLES = 8;     // input and output registers, plus margin
    localparam int LONG_HOLD    = 200;   // receiver hold-off in cycles
    localparam int STORM_CLICKS = 4;     // repeated presses inside the window

    // dut ports
    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic        [23:0] i_click_window = '0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_ready;
    logic        [15:0] i_mode         = '0;
    logic        [15:0] i_event_code   = '0;
    logic signed [31:0] i_event_value  = '0;
    logic        [47:0] i_timestamp    = '0;
    logic               o_out_valid;
    logic               i_out_ready    = 1'b0;
    logic        [1:0]  o_report_kind;
    logic        [2:0]  o_buttons;
    logic        [14:0] o_pos_x;
    logic        [14:0] o_pos_y;
    logic        [7:0]  o_click_count;
    logic signed [15:0] o_wheel_delta;
    logic        [47:0] o_report_time;
    logic               o_last;

    tablet_event_sync_reporter_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_click_window (i_click_window),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_event_code   (i_event_code),
        .i_event_value  (i_event_value),
        .i_timestamp    (i_timestamp),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_report_kind  (o_report_kind),
        .o_buttons      (o_buttons),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_click_count  (o_click_count),
        .o_wheel_delta  (o_wheel_delta),
        .o_report_time  (o_report_time),
        .o_last         (o_last)
    );

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // pointer state as the block should hold it
    // ------------------------------------------------------------------
    logic        [23:0] window_us     = CLICK_WINDOW_RESET;
    logic        [14:0] pend_x        = POS_RESET;
    logic        [14:0] pend_y        = POS_RESET;
    logic        [14:0] disp_x        = POS_RESET;
    logic        [14:0] disp_y        = POS_RESET;
    logic        [2:0]  pend_btn      = '0;
    logic        [2:0]  disp_btn      = '0;
    logic signed [15:0] wheel_acc     = '0;
    logic        [47:0] press_stamp   = '0;
    logic        [1:0]  press_btn     = '0;
    logic               press_seen    = 1'b0;
    logic        [7:0]  press_cnt     = '0;

    t_event  pending_events   [$];   // events not yet offered
    t_report expected_reports [$];   // reports still owed by the block
    t_event  offered_event;
    int      mismatch_count = 0;

    // pacing knobs, written at the falling edge only
    int      in_idle_pct   = 0;
    int      out_stall_pct = 0;
    int      hold_req      = 0;
    logic [47:0] clock_us  = '0;

    function automatic logic [14:0] clamp_pos(logic signed [31:0] v);
        if (v < 0)
            return '0;
        if (v > 32'sd32767)
            return POS_MAX;
        return v[14:0];
    endfunction

    // apply one accepted event, queue the reports it causes
    function automatic void decode_event(t_event ev);
        t_report            burst [5];
        t_report            r;
        int                 n;
        logic [2:0]         mask;
        logic [47:0]        gap;
        longint             wsum;
        logic signed [31:0] val;
        n   = 0;
        val = $signed(ev.event_value);
        case (ev.mode)
            MODE_ABS: begin
                if (ev.event_code == ABS_X)
                    pend_x = clamp_pos(val);
                else if (ev.event_code == ABS_Y)
                    pend_y = clamp_pos(val);
            end
            MODE_REL: begin
                if (ev.event_code == REL_WHEEL) begin
                    wsum = longint'(wheel_acc) - longint'(val);
                    if (wsum < -32768)
                        wheel_acc = WHEEL_MIN;
                    else if (wsum > 32767)
                        wheel_acc = WHEEL_MAX;
                    else
                        wheel_acc = 16'(wsum);
                end
            end
            MODE_KEY: begin
                if (ev.event_code >= KEY_LEFT && ev.event_code <= KEY_MIDDLE) begin
                    mask = 3'b001 << (ev.event_code - KEY_LEFT);
                    if (val != 0)
                        pend_btn |= mask;
                    else
                        pend_btn &= ~mask;
                end
            end
            MODE_SYNC: begin
                // move first, carrying the buttons shown before this sync
                if (pend_x != disp_x || pend_y != disp_y) begin
                    disp_x   = pend_x;
                    disp_y   = pend_y;
                    burst[n] = '{KIND_MOVE, disp_btn, disp_x, disp_y, 8'd0, 16'd0,
                                 ev.timestamp, 1'b0};
                    n++;
                end
                // buttons, lowest bit first
                for (int b = 0; b < 3; b++) begin
                    mask = 3'b001 << b;
                    if (((disp_btn ^ pend_btn) & mask) != 0) begin
                        disp_btn ^= mask;
                        if ((disp_btn & mask) != 0) begin
                            gap = ev.timestamp - press_stamp;
                            if (press_seen && press_btn == 2'(b) && gap <= 48'(window_us))
                                press_cnt = (press_cnt == COUNT_MAX) ? COUNT_MAX
                                                                     : press_cnt + 8'd1;
                            else
                                press_cnt = 8'd1;
                            press_btn   = 2'(b);
                            press_seen  = 1'b1;
                            press_stamp = ev.timestamp;
                            burst[n] = '{KIND_DOWN, disp_btn, disp_x, disp_y, press_cnt,
                                         16'd0, ev.timestamp, 1'b0};
                        end else begin
                            burst[n] = '{KIND_UP, disp_btn, disp_x, disp_y, 8'd0, 16'd0,
                                         ev.timestamp, 1'b0};
                        end
                        n++;
                    end
                end
                if (wheel_acc != 0) begin
                    burst[n] = '{KIND_WHEEL, disp_btn, disp_x, disp_y, 8'd0, wheel_acc,
                                 ev.timestamp, 1'b0};
                    n++;
                    wheel_acc = '0;
                end
                for (int k = 0; k < n; k++) begin
                    r      = burst[k];
                    r.last = (k == n - 1);
                    expected_reports.push_back(r);
                end
            end
            default: ;  // unknown event type, no effect
        endcase
    endfunction

    // ------------------------------------------------------------------
    // event driver: offers queued items, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_events
        logic next_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                decode_event(offered_event);
                next_valid = 1'b0;
            end
            // a new item may follow in the same cycle, so valid stays high
            if (!next_valid && pending_events.size() != 0 &&
                $urandom_range(99) >= in_idle_pct) begin
                offered_event = pending_events.pop_front();
                i_mode        <= offered_event.mode;
                i_event_code  <= offered_event.event_code;
                i_event_value <= offered_event.event_value;
                i_timestamp   <= offered_event.timestamp;
                next_valid    = 1'b1;
            end
            i_in_valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // report side: random stalls plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_ready
        int hold_seen;
        int hold_left;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_seen   = hold_req;
            hold_left   = 0;
        end else if (hold_seen != hold_req) begin
            hold_seen   = hold_req;
            hold_left   = LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // compare each accepted report with the oldest one owed
    always @(posedge i_clk) begin : check_reports
        t_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, got kind %0d time %0h",
                         $time, o_report_kind, o_report_time);
                mismatch_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("report_kind", want.report_kind, o_report_kind);
                check_field("buttons",     want.buttons,     o_buttons);
                check_field("pos_x",       want.pos_x,       o_pos_x);
                check_field("pos_y",       want.pos_y,       o_pos_y);
                check_field("click_count", want.click_count, o_click_count);
                // both sides zero-extended so negative deltas compare bit for bit
                check_field("wheel_delta", want.wheel_delta, $unsigned(o_wheel_delta));
                check_field("report_time", want.report_time, o_report_time);
                check_field("last",        want.last,        o_last);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[47:0];
    endfunction

    function automatic void push_event(logic [15:0] mode, logic [15:0] code,
                                       logic [31:0] value, logic [47:0] stamp);
        t_event ev;
        ev = '{mode, code, value, stamp};
        pending_events.push_back(ev);
    endfunction

    // sync time: inside the window, on or just past its edge, backwards, far jump or same
    function automatic logic [47:0] next_stamp();
        case ($urandom_range(9))
            0, 1, 2, 3: clock_us = clock_us + 48'($urandom_range(window_us));
            4, 5, 6:    clock_us = clock_us + 48'(window_us) + 48'($urandom_range(2));
            7:          clock_us = clock_us - 48'($urandom_range(1000, 1));
            8:          clock_us = rand48();
            default: ;
        endcase
        return clock_us;
    endfunction

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(7))
            0:       return $urandom();
            1:       return -32'($urandom_range(100000, 1));
            2:       return 32'd32767;
            3:       return 32'd0;
            4:       return 32'd32768;
            default: return 32'($urandom_range(32767));
        endcase
    endfunction

    // one well-formed burst of events closed by a sync
    function automatic int add_gesture();
        int          n;
        logic [31:0] v;
        n = 0;
        if ($urandom_range(1)) begin
            push_event(MODE_ABS, ABS_X, pick_pos(), rand48());
            n++;
        end
        if ($urandom_range(1)) begin
            push_event(MODE_ABS, ABS_Y, pick_pos(), rand48());
            n++;
        end
        for (int b = 0; b < 3; b++) begin
            if ($urandom_range(99) < 40) begin
                if ($urandom_range(1))
                    v = '0;
                else if ($urandom_range(1))
                    v = 32'd1;
                else begin
                    v = $urandom();
                    if (v == 0)
                        v = 32'd1;
                end
                push_event(MODE_KEY, KEY_LEFT + 16'(b), v, rand48());
                n++;
            end
        end
        if ($urandom_range(99) < 30) begin
            case ($urandom_range(7))
                6:       v = $urandom();
                7:       v = $urandom_range(1) ? 32'd20000 : -32'd20000;
                default: v = 32'($urandom_range(6)) - 32'd3;
            endcase
            push_event(MODE_REL, REL_WHEEL, v, rand48());
            n++;
        end
        push_event(MODE_SYNC, ($urandom_range(4) == 0) ? 16'($urandom()) : SYN_REPORT,
                   $urandom(), next_stamp());
        return n + 1;
    endfunction

    // random type or code, mostly ignored by the block
    function automatic void add_noise();
        logic [15:0] m;
        case ($urandom_range(3))
            0:       m = 16'($urandom());
            1:       m = MODE_KEY;
            2:       m = MODE_REL;
            default: m = MODE_ABS;
        endcase
        push_event(m, 16'($urandom()), $urandom(), rand48());
    endfunction

    task automatic random_phase(int target);
        int made;
        made = 0;
        while (made < target) begin
            if ($urandom_range(9) == 0)
                add_noise();
            else
                made += add_gesture();
        end
    endtask

    task automatic set_pace(int idle_pct, int stall_pct);
        @(negedge i_clk);
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
    endtask

    // sender pause: nothing queued, nothing offered, nothing owed
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_events.size() != 0 || i_in_valid || expected_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_click_window(logic [23:0] value);
        @(posedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_click_window <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        window_us    = value;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : run_sequence
        logic [47:0] t0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        clock_us = rand48();
        t0       = clock_us;

        // directed part, default click window
        set_pace(0, 0);
        // position clamping on both ends
        push_event(MODE_ABS, ABS_X, -32'd5, t0);
        push_event(MODE_ABS, ABS_Y, 32'd40000, t0);
        push_event(MODE_SYNC, SYN_REPORT, '0, t0);
        // five reports from one sync: move, three downs, saturated wheel
        push_event(MODE_KEY, KEY_LEFT, 32'd1, t0);
        push_event(MODE_KEY, KEY_RIGHT, 32'hffffffff, t0);
        push_event(MODE_KEY, KEY_MIDDLE, 32'h80000000, t0);
        push_event(MODE_REL, REL_WHEEL, 32'h7fffffff, t0);
        push_event(MODE_ABS, ABS_X, 32'h7fffffff, t0);
        push_event(MODE_ABS, ABS_Y, 32'h80000000, t0);
        push_event(MODE_SYNC, 16'hffff, 32'hffffffff, t0 + 48'd1);
        // all up, wheel saturating the other way
        push_event(MODE_KEY, KEY_LEFT, '0, t0);
        push_event(MODE_KEY, KEY_RIGHT, '0, t0);
        push_event(MODE_KEY, KEY_MIDDLE, '0, t0);
        push_event(MODE_REL, REL_WHEEL, 32'h80000000, t0);
        push_event(MODE_SYNC, SYN_REPORT, '0, t0 + 48'd2);
        // sync with nothing changed, then ignored events
        push_event(MODE_SYNC, SYN_REPORT, '0, 48'hffffffffffff);
        push_event(MODE_UNUSED, ABS_X, 32'd7, '0);
        push_event(MODE_KEY, KEY_PAST, 32'd1, '0);
        push_event(MODE_ABS, ABS_UNUSED, 32'd9, '0);
        // second press exactly at the window edge, third one past it
        push_event(MODE_KEY, KEY_LEFT, 32'd1, '0);
        push_event(MODE_SYNC, SYN_REPORT, '0, t0 + 48'd10);
        push_event(MODE_KEY, KEY_LEFT, '0, '0);
        push_event(MODE_SYNC, SYN_REPORT, '0, t0 + 48'd20);
        push_event(MODE_KEY, KEY_LEFT, 32'd1, '0);
        push_event(MODE_SYNC, SYN_REPORT, '0, t0 + 48'd10 + 48'(CLICK_WINDOW_RESET));
        push_event(MODE_KEY, KEY_LEFT, '0, '0);
        push_event(MODE_SYNC, SYN_REPORT, '0, t0 + 48'd20 + 48'(CLICK_WINDOW_RESET));
        push_event(MODE_KEY, KEY_LEFT, 32'd1, '0);
        push_event(MODE_SYNC, SYN_REPORT, '0, t0 + 48'd11 + 48'(2 * CLICK_WINDOW_RESET));
        wait_drained();

        // zero window, no idling
        write_click_window(24'd0);
        set_pace(0, 0);
        random_phase(20);
        wait_drained();

        // widest window: repeated clicks, then a slow sender
        write_click_window(24'hffffff);
        set_pace(0, 0);
        push_event(MODE_KEY, KEY_LEFT, '0, '0);
        push_event(MODE_SYNC, SYN_REPORT, '0, clock_us);
        for (int i = 0; i < STORM_CLICKS; i++) begin
            clock_us = clock_us + 48'd1;
            push_event(MODE_KEY, KEY_LEFT, 32'd1, '0);
            push_event(MODE_SYNC, SYN_REPORT, '0, clock_us);
            push_event(MODE_KEY, KEY_LEFT, '0, '0);
            push_event(MODE_SYNC, SYN_REPORT, '0, clock_us);
        end
        wait_drained();
        set_pace(73, 0);
        random_phase(20);
        wait_drained();

        // random window, stalling receiver
        write_click_window(24'($urandom_range(24'hffffff)));
        set_pace(0, 73);
        random_phase(20);
        wait_drained();

        // short window, light idling on both sides
        write_click_window(24'd1000);
        set_pace(6, 6);
        random_phase(20);
        wait_drained();

        // long receiver hold-off while the sender keeps going
        write_click_window(CLICK_WINDOW_RESET);
        set_pace(0, 0);
        hold_req++;
        random_phase(20);
        wait_drained();

        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
